FILE: hdl/svp_pkg.sv
// Shared types, codes and constants of the stride value predictor.
`default_nettype none
package svp_pkg;

	localparam int INDEX_BITS_DEF  = 10;
	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int TAG_W           = 20;
	localparam int CONF_W          = 5;
	localparam int INST_W          = 7;
	localparam int SLOT_W          = 6;
	localparam int SLOT_SPAN       = 64;
	localparam int FQ_DEPTH        = 2;
	localparam logic [INST_W-1:0] INST_MAX  = 7'd127;
	localparam logic [4:0]        TAG_LIMIT = 5'd20;

	// command codes on the input word
	localparam logic [2:0] CMD_LOOKUP  = 3'd0;
	localparam logic [2:0] CMD_ALLOC   = 3'd1;
	localparam logic [2:0] CMD_TRAIN   = 3'd2;
	localparam logic [2:0] CMD_SQUASH  = 3'd3;
	localparam logic [2:0] CMD_RESTORE = 3'd4;
	localparam logic [2:0] CMD_STALL   = 3'd5;

	// configuration register indexes
	localparam logic [2:0] CFG_TAG_BITS   = 3'd0;
	localparam logic [2:0] CFG_CONF_MAX   = 3'd1;
	localparam logic [2:0] CFG_CONF_INC   = 3'd2;
	localparam logic [2:0] CFG_CONF_DEC   = 3'd3;
	localparam logic [2:0] CFG_STRIDE_LIM = 3'd4;
	localparam logic [2:0] CFG_ENTRY_LIM  = 3'd5;

	localparam logic [4:0] TAG_BITS_RST = 5'd14;
	localparam logic [4:0] CONF_MAX_RST = 5'd7;
	localparam logic [4:0] CONF_INC_RST = 5'd1;
	localparam logic [4:0] CONF_DEC_RST = 5'd0;
	localparam logic [4:0] STRIDE_LIM_RST = 5'd0;
	localparam logic [4:0] ENTRY_LIM_RST  = 5'd0;

	typedef enum logic [2:0] {
		OP_LOOKUP, OP_ALLOC, OP_TRAIN, OP_SQUASH, OP_RESTORE, OP_STALL, OP_NONE
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_LK_RD, ST_LK_ADD, ST_TR_RD, ST_TW_RD, ST_TW_CMP,
		ST_TR_WR, ST_UN_CHK, ST_UN_QRD, ST_UN_TRD, ST_UN_WR
	} st_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [63:0] pc;
		logic [63:0] value;
		logic [5:0]  restore_tail;
		logic        restore_phase;
		logic [6:0]  bundle_count;
	} in_word_t;

	typedef struct packed {
		logic [63:0] prediction;
		logic        confident;
		logic        miss;
		logic [5:0]  slot;
		logic        slot_phase;
		logic        stall_res;
	} out_word_t;

	// classified item handed from the front to the back
	typedef struct packed {
		op_t         op;
		logic [63:0] pc;
		logic [63:0] value;
		logic [5:0]  restore_tail;
		logic        restore_phase;
		logic [6:0]  bundle_count;
	} item_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [CONF_W-1:0] conf;
		logic [63:0]       last_value;
		logic [63:0]       stride;
		logic [INST_W-1:0] inst;
	} entry_t;

endpackage
`default_nettype wire

FILE: hdl/svp_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module svp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: hdl/svp_front.sv
// Front end: accepts input words, classifies the command, buffers in a short queue.
`default_nettype none
module svp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  svp_pkg::in_word_t in_data,
	input  logic             clearing,
	output logic             fq_valid,
	output svp_pkg::item_t   fq_item,
	input  logic             fq_pop
);

	svp_pkg::item_t fifo_q [svp_pkg::FQ_DEPTH];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	svp_pkg::item_t dec_item;
	logic           push;

	// command decode
	always_comb begin
		dec_item.pc            = in_data.pc;
		dec_item.value         = in_data.value;
		dec_item.restore_tail  = in_data.restore_tail;
		dec_item.restore_phase = in_data.restore_phase;
		dec_item.bundle_count  = in_data.bundle_count;
		unique case (in_data.cmd)
			svp_pkg::CMD_LOOKUP:  dec_item.op = svp_pkg::OP_LOOKUP;
			svp_pkg::CMD_ALLOC:   dec_item.op = svp_pkg::OP_ALLOC;
			svp_pkg::CMD_TRAIN:   dec_item.op = svp_pkg::OP_TRAIN;
			svp_pkg::CMD_SQUASH:  dec_item.op = svp_pkg::OP_SQUASH;
			svp_pkg::CMD_RESTORE: dec_item.op = svp_pkg::OP_RESTORE;
			svp_pkg::CMD_STALL:   dec_item.op = svp_pkg::OP_STALL;
			default:              dec_item.op = svp_pkg::OP_NONE;
		endcase
	end

	assign in_ready = (cnt_q != 2'(svp_pkg::FQ_DEPTH)) && !clearing;
	assign push     = in_valid && in_ready;
	assign fq_valid = (cnt_q != 2'd0);
	assign fq_item  = fifo_q[rd_ptr_q];

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (fq_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(fq_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec_item;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/svp_exec.sv
// Back end: sequencer over the predictor table and the in-flight PC queue.
`default_nettype none
module svp_exec #(
	parameter int INDEX_BITS  = svp_pkg::INDEX_BITS_DEF,
	parameter int QUEUE_DEPTH = svp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [2:0]         cfg_index,
	input  logic [4:0]         cfg_data,
	input  logic               fq_valid,
	input  svp_pkg::item_t     fq_item,
	output logic               fq_pop,
	output logic               clearing,
	output logic               out_valid,
	input  logic               out_ready,
	output svp_pkg::out_word_t out_data
);

	localparam int QB = $clog2(QUEUE_DEPTH);
	localparam int CW = (QB + 2 > 8) ? QB + 2 : 8;
	localparam logic [QB-1:0] QLAST = QB'(QUEUE_DEPTH - 1);

	// slot index modulo the queue depth, for restore targets
	function automatic logic [svp_pkg::SLOT_SPAN*QB-1:0] mod_tbl();
		logic [svp_pkg::SLOT_SPAN*QB-1:0] t;
		int r;
		t = '0;
		r = 0;
		for (int i = 0; i < svp_pkg::SLOT_SPAN; i++) begin
			t[i*QB +: QB] = QB'(r);
			r = (r == QUEUE_DEPTH - 1) ? 0 : r + 1;
		end
		return t;
	endfunction

	localparam logic [svp_pkg::SLOT_SPAN*QB-1:0] MOD_TBL = mod_tbl();

	function automatic logic [INDEX_BITS-1:0] idx_of(input logic [63:0] pc);
		return pc[2 +: INDEX_BITS];
	endfunction

	function automatic logic [svp_pkg::TAG_W-1:0] tag_of(input logic [63:0] pc,
			input logic [4:0] tb);
		logic [svp_pkg::TAG_W-1:0] m;
		logic [4:0] te;
		te = (tb > svp_pkg::TAG_LIMIT) ? svp_pkg::TAG_LIMIT : tb;
		for (int k = 0; k < svp_pkg::TAG_W; k++) begin
			m[k] = (5'(k) < te);
		end
		return pc[INDEX_BITS+2 +: svp_pkg::TAG_W] & m;
	endfunction

	// configuration
	logic [4:0] tag_bits_q, conf_max_q, conf_inc_q, conf_dec_q, srl_q, erl_q;

	// control state
	svp_pkg::st_t    state_q, state_nx;
	logic [INDEX_BITS-1:0] clr_q;
	logic [QB-1:0]   head_q, tail_q;
	logic            hph_q, tph_q;
	logic            out_valid_q;

	// working registers
	svp_pkg::item_t  cur_q;
	svp_pkg::entry_t ent_q;
	logic [63:0]     prod_q;
	logic            lk_conf_q, lk_miss_q;
	logic [QB-1:0]   slot_q, target_q;
	logic [svp_pkg::INST_W-1:0] cnt_q;
	logic            is_rst_q;
	logic [63:0]     upc_q;
	svp_pkg::out_word_t out_q;

	// memory ports
	logic                  tbl_we;
	logic [INDEX_BITS-1:0] tbl_waddr, tbl_raddr;
	svp_pkg::entry_t       tbl_wdata, ent;
	logic                  q_we;
	logic [QB-1:0]         q_waddr, q_raddr;
	logic [63:0]           q_wdata, q_rdata;

	// helpers
	logic            issue, empty, hit_cur, hit_un, repl, walk_start, un_done, stall_w;
	logic            emit, fin_train;
	logic [QB-1:0]   head_nx, slot_nx;
	logic [svp_pkg::INST_W-1:0] inst_inc;
	logic [70:0]     prod_w;
	logic [63:0]     ns;
	logic [5:0]      c6;
	logic [CW-1:0]   fr_eq, fr_ne, need;
	svp_pkg::entry_t tr_upd, rep_ent;
	svp_pkg::out_word_t emit_word;

	svp_ram #(.WIDTH($bits(svp_pkg::entry_t)), .DEPTH(2 ** INDEX_BITS)) u_tbl (
		.clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
		.raddr(tbl_raddr), .rdata(ent)
	);

	svp_ram #(.WIDTH(64), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata)
	);

	assign clearing  = (state_q == svp_pkg::ST_CLEAR);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign issue   = fq_valid && (!out_valid_q || out_ready)
		&& (state_q == svp_pkg::ST_IDLE);
	assign empty   = (head_q == tail_q) && (hph_q == tph_q);
	assign head_nx = (head_q == QLAST) ? '0 : head_q + QB'(1);
	assign slot_nx = (slot_q == QLAST) ? '0 : slot_q + QB'(1);
	assign hit_cur = (tag_bits_q == 5'd0) || (ent.tag == tag_of(cur_q.pc, tag_bits_q));
	assign hit_un  = (tag_bits_q == 5'd0) || (ent.tag == tag_of(upc_q, tag_bits_q));
	assign repl    = (ent.conf <= erl_q);
	assign walk_start = !empty && (head_nx != tail_q);
	assign un_done = is_rst_q ? (tail_q == target_q)
		: ((tail_q == head_q) && (tph_q == hph_q));
	assign fin_train = ((state_q == svp_pkg::ST_TR_RD) && (hit_cur || !repl))
		|| (state_q == svp_pkg::ST_TR_WR);

	// lookup: saturating instance bump and product
	assign inst_inc = (ent.inst < svp_pkg::INST_MAX) ? ent.inst + 7'd1 : ent.inst;
	assign prod_w   = 71'(ent.stride) * 71'(inst_inc);

	// free slot count for the stall check
	assign fr_eq   = CW'(QUEUE_DEPTH) + CW'(head_q) - CW'(tail_q);
	assign fr_ne   = CW'(head_q) - CW'(tail_q);
	assign need    = CW'(fq_item.bundle_count);
	assign stall_w = (tph_q == hph_q) ? (fr_eq < need)
		: ((head_q >= tail_q) && (fr_ne < need));

	// training on a hit
	always_comb begin
		ns = cur_q.value - ent.last_value;
		c6 = {1'b0, ent.conf} + {1'b0, conf_inc_q};
		tr_upd = ent;
		if (ns == ent.stride) begin
			tr_upd.conf = (c6 > {1'b0, conf_max_q}) ? conf_max_q : c6[4:0];
		end else begin
			if (ent.conf <= srl_q) tr_upd.stride = ns;
			tr_upd.conf = (conf_dec_q != 5'd0 && conf_dec_q <= ent.conf)
				? ent.conf - conf_dec_q : 5'd0;
		end
		tr_upd.last_value = cur_q.value;
		tr_upd.inst = (ent.inst != '0) ? ent.inst - 7'd1 : '0;
	end

	// replacement entry, instance count filled in after the walk
	always_comb begin
		rep_ent            = ent;
		rep_ent.tag        = (tag_bits_q != 5'd0) ? tag_of(cur_q.pc, tag_bits_q) : ent.tag;
		rep_ent.conf       = '0;
		rep_ent.last_value = cur_q.value;
		rep_ent.stride     = cur_q.value;
		rep_ent.inst       = '0;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			svp_pkg::ST_CLEAR: if (&clr_q) state_nx = svp_pkg::ST_IDLE;
			svp_pkg::ST_IDLE: begin
				if (issue) begin
					case (fq_item.op)
						svp_pkg::OP_LOOKUP: state_nx = svp_pkg::ST_LK_RD;
						svp_pkg::OP_TRAIN:  state_nx = svp_pkg::ST_TR_RD;
						svp_pkg::OP_SQUASH, svp_pkg::OP_RESTORE:
							state_nx = svp_pkg::ST_UN_CHK;
						default: state_nx = svp_pkg::ST_IDLE;
					endcase
				end
			end
			svp_pkg::ST_LK_RD:  state_nx = svp_pkg::ST_LK_ADD;
			svp_pkg::ST_LK_ADD: state_nx = svp_pkg::ST_IDLE;
			svp_pkg::ST_TR_RD: begin
				if (hit_cur || !repl) state_nx = svp_pkg::ST_IDLE;
				else if (walk_start) state_nx = svp_pkg::ST_TW_RD;
				else state_nx = svp_pkg::ST_TR_WR;
			end
			svp_pkg::ST_TW_RD:  state_nx = svp_pkg::ST_TW_CMP;
			svp_pkg::ST_TW_CMP: state_nx = (slot_nx == tail_q) ? svp_pkg::ST_TR_WR
				: svp_pkg::ST_TW_RD;
			svp_pkg::ST_TR_WR:  state_nx = svp_pkg::ST_IDLE;
			svp_pkg::ST_UN_CHK: state_nx = un_done ? svp_pkg::ST_IDLE : svp_pkg::ST_UN_QRD;
			svp_pkg::ST_UN_QRD: state_nx = svp_pkg::ST_UN_TRD;
			svp_pkg::ST_UN_TRD: state_nx = svp_pkg::ST_UN_WR;
			svp_pkg::ST_UN_WR:  state_nx = svp_pkg::ST_UN_CHK;
			default:            state_nx = svp_pkg::ST_IDLE;
		endcase
	end

	// memory controls and result word
	always_comb begin
		fq_pop    = 1'b0;
		tbl_we    = 1'b0;
		tbl_waddr = idx_of(cur_q.pc);
		tbl_wdata = ent;
		tbl_raddr = idx_of(cur_q.pc);
		q_we      = 1'b0;
		q_waddr   = tail_q;
		q_wdata   = fq_item.pc;
		q_raddr   = slot_q;
		emit      = 1'b0;
		emit_word = '0;
		unique case (state_q)
			svp_pkg::ST_CLEAR: begin
				tbl_we    = 1'b1;
				tbl_waddr = clr_q;
				tbl_wdata = '0;
			end
			svp_pkg::ST_IDLE: begin
				if (issue) begin
					fq_pop    = 1'b1;
					tbl_raddr = idx_of(fq_item.pc);
					case (fq_item.op)
						svp_pkg::OP_ALLOC: begin
							q_we                 = 1'b1;
							emit                 = 1'b1;
							emit_word.slot       = svp_pkg::SLOT_W'(tail_q);
							emit_word.slot_phase = tph_q;
						end
						svp_pkg::OP_STALL: begin
							emit                = 1'b1;
							emit_word.stall_res = stall_w;
						end
						svp_pkg::OP_NONE: emit = 1'b1;
						default: ;
					endcase
				end
			end
			svp_pkg::ST_LK_RD: begin
				tbl_we         = 1'b1;
				tbl_wdata.inst = inst_inc;
			end
			svp_pkg::ST_LK_ADD: begin
				emit                 = 1'b1;
				emit_word.prediction = ent_q.last_value + prod_q;
				emit_word.confident  = lk_conf_q;
				emit_word.miss       = lk_miss_q;
			end
			svp_pkg::ST_TR_RD: begin
				if (hit_cur) begin
					tbl_we    = 1'b1;
					tbl_wdata = tr_upd;
					emit      = 1'b1;
				end else if (!repl) begin
					emit = 1'b1;
				end
			end
			svp_pkg::ST_TR_WR: begin
				tbl_we         = 1'b1;
				tbl_wdata      = ent_q;
				tbl_wdata.inst = cnt_q;
				emit           = 1'b1;
			end
			svp_pkg::ST_UN_CHK: emit = un_done;
			svp_pkg::ST_UN_QRD: q_raddr = tail_q;
			svp_pkg::ST_UN_TRD: tbl_raddr = idx_of(q_rdata);
			svp_pkg::ST_UN_WR: begin
				tbl_waddr = idx_of(upc_q);
				if (hit_un && ent.inst != '0) begin
					tbl_we         = 1'b1;
					tbl_wdata.inst = ent.inst - 7'd1;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= svp_pkg::ST_CLEAR;
			clr_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			hph_q       <= 1'b0;
			tph_q       <= 1'b0;
			out_valid_q <= 1'b0;
			tag_bits_q  <= svp_pkg::TAG_BITS_RST;
			conf_max_q  <= svp_pkg::CONF_MAX_RST;
			conf_inc_q  <= svp_pkg::CONF_INC_RST;
			conf_dec_q  <= svp_pkg::CONF_DEC_RST;
			srl_q       <= svp_pkg::STRIDE_LIM_RST;
			erl_q       <= svp_pkg::ENTRY_LIM_RST;
		end else begin
			state_q <= state_nx;
			if (state_q == svp_pkg::ST_CLEAR) clr_q <= clr_q + INDEX_BITS'(1);

			if (cfg_valid) begin
				unique case (cfg_index)
					svp_pkg::CFG_TAG_BITS:   tag_bits_q <= cfg_data;
					svp_pkg::CFG_CONF_MAX:   conf_max_q <= cfg_data;
					svp_pkg::CFG_CONF_INC:   conf_inc_q <= cfg_data;
					svp_pkg::CFG_CONF_DEC:   conf_dec_q <= cfg_data;
					svp_pkg::CFG_STRIDE_LIM: srl_q      <= cfg_data;
					svp_pkg::CFG_ENTRY_LIM:  erl_q      <= cfg_data;
					default: ;
				endcase
			end

			// allocate advances the tail
			if (issue && fq_item.op == svp_pkg::OP_ALLOC) begin
				tail_q <= (tail_q == QLAST) ? '0 : tail_q + QB'(1);
				if (tail_q == QLAST) tph_q <= ~tph_q;
			end
			if (issue && fq_item.op == svp_pkg::OP_RESTORE) tph_q <= fq_item.restore_phase;

			// retire pops the head
			if (fin_train && !empty) begin
				head_q <= head_nx;
				if (head_q == QLAST) hph_q <= ~hph_q;
			end

			// squash / restore tail walk
			if (state_q == svp_pkg::ST_UN_CHK) begin
				if (un_done) begin
					if (!is_rst_q) tph_q <= hph_q;
				end else begin
					tail_q <= (tail_q == '0) ? QLAST : tail_q - QB'(1);
					if (tail_q == '0 && !is_rst_q) tph_q <= hph_q;
				end
			end

			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (issue) begin
			cur_q    <= fq_item;
			is_rst_q <= (fq_item.op == svp_pkg::OP_RESTORE);
			target_q <= MOD_TBL[fq_item.restore_tail*QB +: QB];
		end
		if (state_q == svp_pkg::ST_LK_RD) begin
			prod_q    <= prod_w[63:0];
			ent_q     <= ent;
			lk_conf_q <= hit_cur && (ent.conf == conf_max_q);
			lk_miss_q <= !hit_cur;
		end
		if (state_q == svp_pkg::ST_TR_RD) begin
			ent_q  <= rep_ent;
			cnt_q  <= '0;
			slot_q <= head_nx;
		end
		if (state_q == svp_pkg::ST_TW_CMP) begin
			if (q_rdata == cur_q.pc && cnt_q < svp_pkg::INST_MAX) cnt_q <= cnt_q + 7'd1;
			slot_q <= slot_nx;
		end
		if (state_q == svp_pkg::ST_UN_TRD) upc_q <= q_rdata;
		if (emit) out_q <= emit_word;
	end

endmodule
`default_nettype wire

FILE: hdl/stride_value_predictor.sv
// Stride value predictor top level: front end, queue and execution back end.
//
// Usage: words enter on in_valid/in_ready (in_data), results leave on
// out_valid/out_ready (out_data), one result word per input word, in order.
// Configuration registers are written on cfg_valid/cfg_ready (always ready),
// cfg_index selecting the register and cfg_data its 5-bit value.
// A two-entry queue sits between the front end and the back end, so input
// words keep being taken while a result waits on a stalled receiver.
// Steps per word in the back end, set by its sequencer and the registered
// table read: allocate, stall check and unused commands are answered at
// issue; lookup does table read, multiply, add; train hit reads and updates
// the entry; train replacement reads, walks queue slots, then writes; squash
// and restore per slot walked back: check, queue read, table read, table write.
// The back end starts a word only when the output register is free or drains.
// After reset the table is cleared, one entry per cycle over all 2**INDEX_BITS
// entries; no input word is taken during that pass.
`default_nettype none
module stride_value_predictor #(
	parameter int INDEX_BITS  = svp_pkg::INDEX_BITS_DEF,
	parameter int QUEUE_DEPTH = svp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  svp_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output svp_pkg::out_word_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [4:0]         cfg_data
);

	logic           fq_valid;
	logic           fq_pop;
	logic           clearing;
	svp_pkg::item_t fq_item;

	assign cfg_ready = 1'b1;

	svp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.clearing(clearing),
		.fq_valid(fq_valid), .fq_item(fq_item), .fq_pop(fq_pop)
	);

	svp_exec #(.INDEX_BITS(INDEX_BITS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_exec (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fq_valid(fq_valid), .fq_item(fq_item), .fq_pop(fq_pop),
		.clearing(clearing),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule
`default_nettype wire
